FILE: design/mfp_pkg.sv
// Shared types, constants and CRC helpers for the MAVLink frame parser.
// Used by mfp_front, mfp_queue, mfp_back and mavlink_frame_parser.
`default_nettype none

package mfp_pkg;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_LEN      = 4'd1,
      PH_INCOMPAT = 4'd2,
      PH_COMPAT   = 4'd3,
      PH_SEQ      = 4'd4,
      PH_SYS      = 4'd5,
      PH_COMP     = 4'd6,
      PH_ID0      = 4'd7,
      PH_ID1      = 4'd8,
      PH_ID2      = 4'd9,
      PH_DATA     = 4'd10,
      PH_CRCLO    = 4'd11,
      PH_CRCHI    = 4'd12
   } phase_type;

   typedef enum logic {
      DR_IDLE,
      DR_SEND
   } drain_type;

   localparam logic [7:0]  START_V1 = 8'hFE;
   localparam logic [7:0]  START_V2 = 8'hFD;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;

   localparam logic [23:0] MSG_HEARTBEAT      = 24'd0;
   localparam logic [23:0] MSG_SYS_STATUS     = 24'd1;
   localparam logic [23:0] MSG_ATTITUDE       = 24'd30;
   localparam logic [23:0] MSG_GLOBAL_POS_INT = 24'd33;
   localparam logic [23:0] MSG_COMMAND_LONG   = 24'd76;
   localparam logic [23:0] MSG_COMMAND_ACK    = 24'd77;

   typedef struct packed {
      logic        bank;
      logic [23:0] msgid;
      logic [7:0]  sys;
      logic [7:0]  comp;
      logic [7:0]  seq;
      logic [7:0]  incompat;
      logic [7:0]  compat;
      logic        v2;
      logic [7:0]  length;
   } desc_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] t;
      t = b ^ crc[7:0];
      t = t ^ {t[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
   endfunction

   function automatic logic [7:0] crc_extra(input logic [23:0] id);
      logic [7:0] e;
      unique case (id)
         MSG_HEARTBEAT:      e = 8'd50;
         MSG_SYS_STATUS:     e = 8'd124;
         MSG_ATTITUDE:       e = 8'd39;
         MSG_GLOBAL_POS_INT: e = 8'd104;
         MSG_COMMAND_LONG:   e = 8'd152;
         MSG_COMMAND_ACK:    e = 8'd143;
         default:            e = 8'd0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: design/mfp_front.sv
// Byte parser: hunts start bytes, walks the header, writes the payload bank,
// checks the CRC and pushes a frame descriptor. Depends on mfp_pkg.
`default_nettype none

module mfp_front
   import mfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64,
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    rx_byte,
   output logic               push,
   output desc_type           push_desc,
   output logic               wr_en,
   output logic               wr_bank,
   output logic [AW-1:0]      wr_addr,
   output logic [7:0]         wr_data,
   input  wire release_type   rel
);

   phase_type        phase_ff, phase_in;
   logic             v2_ff, v2_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [7:0]       incompat_ff, incompat_in;
   logic [7:0]       compat_ff, compat_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       sys_ff, sys_in;
   logic [7:0]       comp_ff, comp_in;
   logic [23:0]      msgid_ff, msgid_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [15:0]      crc_ff, crc_in;
   logic             wbank_ff, wbank_in;
   logic [1:0]       busy_ff, busy_in;
   logic             stall;
   logic             accept;
   logic [15:0]      crc_step;
   logic [15:0]      crc_final;
   logic [CW-1:0]    count_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         v2_ff       <= 1'b0;
         len_ff      <= '0;
         incompat_ff <= '0;
         compat_ff   <= '0;
         seq_ff      <= '0;
         sys_ff      <= '0;
         comp_ff     <= '0;
         msgid_ff    <= '0;
         count_ff    <= '0;
         crc_lo_ff   <= '0;
         crc_ff      <= CRC_SEED;
         wbank_ff    <= 1'b0;
         busy_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         v2_ff       <= v2_in;
         len_ff      <= len_in;
         incompat_ff <= incompat_in;
         compat_ff   <= compat_in;
         seq_ff      <= seq_in;
         sys_ff      <= sys_in;
         comp_ff     <= comp_in;
         msgid_ff    <= msgid_in;
         count_ff    <= count_in;
         crc_lo_ff   <= crc_lo_in;
         crc_ff      <= crc_in;
         wbank_ff    <= wbank_in;
         busy_ff     <= busy_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      v2_in       = v2_ff;
      len_in      = len_ff;
      incompat_in = incompat_ff;
      compat_in   = compat_ff;
      seq_in      = seq_ff;
      sys_in      = sys_ff;
      comp_in     = comp_ff;
      msgid_in    = msgid_ff;
      count_in    = count_ff;
      crc_lo_in   = crc_lo_ff;
      crc_in      = crc_ff;
      wbank_in    = wbank_ff;
      push        = 1'b0;
      wr_en       = 1'b0;

      stall      = busy_ff[wbank_ff] && (phase_ff == PH_DATA || phase_ff == PH_CRCHI);
      req_tready = !stall;
      accept     = req_tvalid && req_tready;
      crc_step   = crc_feed(crc_ff, rx_byte);
      crc_final  = crc_feed(crc_ff, crc_extra(msgid_ff));
      count_next = count_ff + 1'b1;

      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (rx_byte == START_V2 || rx_byte == START_V1) begin
                  v2_in    = (rx_byte == START_V2);
                  crc_in   = CRC_SEED;
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if (rx_byte > 8'(MAX_PAYLOAD)) begin
                  phase_in = PH_IDLE;
               end else begin
                  len_in = rx_byte[CW-1:0];
                  crc_in = crc_step;
                  if (v2_ff) begin
                     phase_in = PH_INCOMPAT;
                  end else begin
                     incompat_in = '0;
                     compat_in   = '0;
                     phase_in    = PH_SEQ;
                  end
               end
            end
            PH_INCOMPAT: begin
               incompat_in = rx_byte;
               crc_in      = crc_step;
               phase_in    = PH_COMPAT;
            end
            PH_COMPAT: begin
               compat_in = rx_byte;
               crc_in    = crc_step;
               phase_in  = PH_SEQ;
            end
            PH_SEQ: begin
               seq_in   = rx_byte;
               crc_in   = crc_step;
               phase_in = PH_SYS;
            end
            PH_SYS: begin
               sys_in   = rx_byte;
               crc_in   = crc_step;
               phase_in = PH_COMP;
            end
            PH_COMP: begin
               comp_in  = rx_byte;
               crc_in   = crc_step;
               phase_in = PH_ID0;
            end
            PH_ID0: begin
               msgid_in = {16'h0000, rx_byte};
               crc_in   = crc_step;
               if (v2_ff) begin
                  phase_in = PH_ID1;
               end else begin
                  count_in = '0;
                  phase_in = (len_ff != '0) ? PH_DATA : PH_CRCLO;
               end
            end
            PH_ID1: begin
               msgid_in = {msgid_ff[23:16], rx_byte, msgid_ff[7:0]};
               crc_in   = crc_step;
               phase_in = PH_ID2;
            end
            PH_ID2: begin
               msgid_in = {rx_byte, msgid_ff[15:0]};
               crc_in   = crc_step;
               count_in = '0;
               phase_in = (len_ff != '0) ? PH_DATA : PH_CRCLO;
            end
            PH_DATA: begin
               wr_en    = 1'b1;
               crc_in   = crc_step;
               count_in = count_next;
               if (count_next == len_ff) begin
                  phase_in = PH_CRCLO;
               end
            end
            PH_CRCLO: begin
               crc_lo_in = rx_byte;
               phase_in  = PH_CRCHI;
            end
            PH_CRCHI: begin
               crc_in   = crc_final;
               phase_in = PH_IDLE;
               if (crc_final == {rx_byte, crc_lo_ff}) begin
                  push     = 1'b1;
                  wbank_in = !wbank_ff;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (push) begin
         busy_in[wbank_ff] = 1'b1;
      end
   end

   assign wr_bank = wbank_ff;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = rx_byte;

   assign push_desc.bank     = wbank_ff;
   assign push_desc.msgid    = msgid_ff;
   assign push_desc.sys      = sys_ff;
   assign push_desc.comp     = comp_ff;
   assign push_desc.seq      = seq_ff;
   assign push_desc.incompat = v2_ff ? incompat_ff : 8'h00;
   assign push_desc.compat   = v2_ff ? compat_ff : 8'h00;
   assign push_desc.v2       = v2_ff;
   assign push_desc.length   = 8'(len_ff);

`ifndef NO_ASSERTIONS
   a_push_free_bank: assert property (@(posedge clock) disable iff (reset)
      push |-> !busy_ff[wbank_ff])
      else $error("descriptor pushed onto a bank still pending");

   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      rel.valid |-> busy_ff[rel.bank])
      else $error("release of a bank that was not pending");
`endif

endmodule

`default_nettype wire

FILE: design/mfp_queue.sv
// Two-entry descriptor queue between the parser and the drain stage.
// Depends on mfp_pkg for desc_type.
`default_nettype none

module mfp_queue
   import mfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire desc_type in_desc,
   output logic          out_valid,
   input  wire logic     out_ready,
   output desc_type      out_desc
);

   desc_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   always_ff @(posedge clock) begin
      if (in_valid) begin
         entry_ff[wr_ptr_ff] <= in_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      out_valid = (count_ff != 2'd0);
      pop       = out_valid && out_ready;
      wr_ptr_in = in_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, in_valid} - {1'b0, pop};
   end

   assign out_desc = entry_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (count_ff != 2'd2 || pop))
      else $error("descriptor queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("descriptor queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: design/mfp_back.sv
// Drain stage: holds the two payload banks, pops descriptors and emits one result
// per payload byte (one for an empty frame) through a registered output. Depends on mfp_pkg.
`default_nettype none

module mfp_back
   import mfp_pkg::*;
#(
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic          wr_bank,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          q_valid,
   output logic               q_ready,
   input  wire desc_type      q_desc,
   output release_type        rel,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [87:0]        rsp_tdata,
   output logic               rsp_tlast
);

   localparam int DEPTH = 2 ** (AW + 1);

   logic [7:0]    mem [DEPTH];
   drain_type     state_ff, state_in;
   desc_type      desc_ff, desc_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   desc_type      rsp_desc_ff;
   logic [CW-1:0] rsp_idx_ff;
   logic          rsp_last_ff;
   logic [7:0]    rd_data_ff;
   logic          load;
   logic [CW-1:0] len;
   logic [CW-1:0] count_n;
   logic          is_last;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{wr_bank, wr_addr}] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rd_data_ff  <= mem[{desc_ff.bank, idx_ff[AW-1:0]}];
         rsp_desc_ff <= desc_ff;
         rsp_idx_ff  <= idx_ff;
         rsp_last_ff <= is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DR_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
   end

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      q_ready      = 1'b0;
      load         = 1'b0;
      rel.valid    = 1'b0;
      rel.bank     = desc_ff.bank;

      len     = desc_ff.length[CW-1:0];
      count_n = (len == '0) ? CW'(1) : len;
      is_last = ((idx_ff + 1'b1) == count_n);

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         DR_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               desc_in  = q_desc;
               idx_in   = '0;
               state_in = DR_SEND;
            end
         end
         DR_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (is_last) begin
                  rel.valid = 1'b1;
                  state_in  = DR_IDLE;
               end
            end
         end
         default: begin
            state_in = DR_IDLE;
         end
      endcase
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_tlast         = rsp_last_ff;
   assign rsp_tdata[23:0]   = rsp_desc_ff.msgid;
   assign rsp_tdata[31:24]  = rsp_desc_ff.sys;
   assign rsp_tdata[39:32]  = rsp_desc_ff.comp;
   assign rsp_tdata[47:40]  = rsp_desc_ff.seq;
   assign rsp_tdata[55:48]  = rsp_desc_ff.incompat;
   assign rsp_tdata[63:56]  = rsp_desc_ff.compat;
   assign rsp_tdata[64]     = rsp_desc_ff.v2;
   assign rsp_tdata[71:65]  = 7'(rsp_desc_ff.length);
   assign rsp_tdata[77:72]  = 6'(rsp_idx_ff);
   assign rsp_tdata[85:78]  = (rsp_desc_ff.length == 8'd0) ? 8'h00 : rd_data_ff;
   assign rsp_tdata[87:86]  = 2'b00;

`ifndef NO_ASSERTIONS
   a_release_ends_send: assert property (@(posedge clock) disable iff (reset)
      rel.valid |=> state_ff == DR_IDLE && rsp_tvalid && rsp_tlast)
      else $error("frame release without a final result");
`endif

endmodule

`default_nettype wire

FILE: design/mavlink_frame_parser.sv
// MAVLink v1/v2 frame parser, top level.
// Instantiates mfp_front, mfp_queue and mfp_back; depends on mfp_pkg.
//
// Usage:
//   req_*: one raw link byte per transaction on req_tdata[7:0].
//   rsp_*: one transaction per payload byte of a frame whose CRC matched,
//          or a single transaction with payload byte zero for an empty frame;
//          rsp_tlast marks the final transaction of a frame.
// Throughput: one byte per cycle on req_. Payload lands in one of two banks;
//   req_tready drops only when the parser reaches payload or CRC high byte of a new
//   frame while both banks still hold frames waiting to be drained.
// Path: with the drain stage idle, a frame passing CRC goes through the queue
//   entry, drain descriptor and output registers; results then follow one per
//   cycle while rsp_tready is high, with a gap between frames for the descriptor pop.
// Stall: if rsp_tready is low the output register holds its transaction;
//   the parser keeps taking bytes until it needs a bank while both are pending.
// Reset: synchronous, active high; clears parser, queue and bank state.
//   The payload banks are not cleared, and no unwritten entry is read.
`default_nettype none

module mavlink_frame_parser
   import mfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,   // message_id[23:0], source_system[31:24],
                                         // source_component[39:32],
                                         // sequence_number[47:40],
                                         // incompat_flags[55:48], compat_flags[63:56],
                                         // is_version_two[64], payload_length[71:65],
                                         // byte_index[77:72], payload_byte[85:78],
                                         // zero pad[87:86]
   output logic             rsp_tlast
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CW = $clog2(MAX_PAYLOAD + 1);

   logic          push;
   desc_type      push_desc;
   logic          wr_en;
   logic          wr_bank;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   release_type   rel;
   logic          q_valid;
   logic          q_ready;
   desc_type      q_desc;

   mfp_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .AW(AW),
      .CW(CW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rx_byte(req_tdata),
      .push(push),
      .push_desc(push_desc),
      .wr_en(wr_en),
      .wr_bank(wr_bank),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rel(rel)
   );

   mfp_queue u_queue (
      .clock(clock),
      .reset(reset),
      .in_valid(push),
      .in_desc(push_desc),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_desc(q_desc)
   );

   mfp_back #(
      .AW(AW),
      .CW(CW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .wr_en(wr_en),
      .wr_bank(wr_bank),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .q_valid(q_valid),
      .q_ready(q_ready),
      .q_desc(q_desc),
      .rel(rel),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: bench/mavlink_frame_checker.sv
// Checker for mavlink_frame_parser: follows accepted link bytes, rebuilds each frame,
// and compares every result transaction against the predicted payload stream.
// Depends on mfp_pkg for phase codes, start bytes, CRC seed and message ids.
module mavlink_frame_checker
   import mfp_pkg::*;
#(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending,
   output int          results_checked,
   output int          frames_passed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [23:0] msgid;
      logic [7:0]  sys;
      logic [7:0]  comp;
      logic [7:0]  seq;
      logic [7:0]  incompat;
      logic [7:0]  compat;
      logic        v2;
      logic [6:0]  length;
      logic [5:0]  index;
      logic [7:0]  data;
      logic        last;
   } frame_beat_type;

   frame_beat_type beats_due[$];

   phase_type   link_phase;
   logic        is_v2;
   logic [6:0]  frame_len;
   logic [7:0]  incompat_flags;
   logic [7:0]  compat_flags;
   logic [7:0]  seq_byte;
   logic [7:0]  sys_byte;
   logic [7:0]  comp_byte;
   logic [23:0] frame_id;
   logic [7:0]  payload_mem [MAX_PAYLOAD];
   logic [6:0]  payload_fill;
   logic [15:0] crc_rx;
   logic [15:0] crc_run;

   initial begin
      error_count = 0;
      pending = 0;
      results_checked = 0;
      frames_passed = 0;
   end

   function automatic logic [15:0] mcrf4xx_step(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  mix;
      logic [15:0] wide;
      mix = b ^ crc[7:0];
      mix = mix ^ (mix << 4);
      wide = {8'h00, mix};
      return (crc >> 8) ^ (wide << 8) ^ (wide << 3) ^ (wide >> 4);
   endfunction

   function automatic logic [7:0] closing_byte(input logic [23:0] id);
      case (id)
         MSG_HEARTBEAT:      return 8'd50;
         MSG_SYS_STATUS:     return 8'd124;
         MSG_ATTITUDE:       return 8'd39;
         MSG_GLOBAL_POS_INT: return 8'd104;
         MSG_COMMAND_LONG:   return 8'd152;
         MSG_COMMAND_ACK:    return 8'd143;
         default:            return 8'd0;
      endcase
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic [23:0] got,
                                input logic [23:0] want);
      if (got !== want) log_error($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic clear_parser();
      link_phase = PH_IDLE;
      is_v2 = 1'b0;
      frame_len = '0;
      incompat_flags = '0;
      compat_flags = '0;
      seq_byte = '0;
      sys_byte = '0;
      comp_byte = '0;
      frame_id = '0;
      payload_fill = '0;
      crc_rx = '0;
      crc_run = CRC_SEED;
   endtask

   task automatic open_payload();
      payload_fill = '0;
      link_phase = (frame_len != 0) ? PH_DATA : PH_CRCLO;
   endtask

   task automatic parse_link_byte(input logic [7:0] b);
      int n;
      frame_beat_type beat;
      case (link_phase)
         PH_IDLE: begin
            if (b == START_V1 || b == START_V2) begin
               is_v2 = (b == START_V2);
               crc_run = CRC_SEED;
               link_phase = PH_LEN;
            end
         end
         PH_LEN: begin
            if (int'(b) > MAX_PAYLOAD) begin
               link_phase = PH_IDLE;
            end else begin
               frame_len = b[6:0];
               crc_run = mcrf4xx_step(crc_run, b);
               if (is_v2) begin
                  link_phase = PH_INCOMPAT;
               end else begin
                  incompat_flags = '0;
                  compat_flags = '0;
                  link_phase = PH_SEQ;
               end
            end
         end
         PH_INCOMPAT: begin
            incompat_flags = b;
            crc_run = mcrf4xx_step(crc_run, b);
            link_phase = PH_COMPAT;
         end
         PH_COMPAT: begin
            compat_flags = b;
            crc_run = mcrf4xx_step(crc_run, b);
            link_phase = PH_SEQ;
         end
         PH_SEQ: begin
            seq_byte = b;
            crc_run = mcrf4xx_step(crc_run, b);
            link_phase = PH_SYS;
         end
         PH_SYS: begin
            sys_byte = b;
            crc_run = mcrf4xx_step(crc_run, b);
            link_phase = PH_COMP;
         end
         PH_COMP: begin
            comp_byte = b;
            crc_run = mcrf4xx_step(crc_run, b);
            link_phase = PH_ID0;
         end
         PH_ID0: begin
            frame_id = {16'h0000, b};
            crc_run = mcrf4xx_step(crc_run, b);
            if (is_v2) link_phase = PH_ID1;
            else open_payload();
         end
         PH_ID1: begin
            frame_id[15:8] = b;
            crc_run = mcrf4xx_step(crc_run, b);
            link_phase = PH_ID2;
         end
         PH_ID2: begin
            frame_id[23:16] = b;
            crc_run = mcrf4xx_step(crc_run, b);
            open_payload();
         end
         PH_DATA: begin
            if (int'(payload_fill) < MAX_PAYLOAD) payload_mem[payload_fill] = b;
            crc_run = mcrf4xx_step(crc_run, b);
            payload_fill++;
            if (payload_fill >= frame_len) link_phase = PH_CRCLO;
         end
         PH_CRCLO: begin
            crc_rx = {8'h00, b};
            link_phase = PH_CRCHI;
         end
         PH_CRCHI: begin
            crc_rx[15:8] = b;
            link_phase = PH_IDLE;
            crc_run = mcrf4xx_step(crc_run, closing_byte(frame_id));
            if (crc_run == crc_rx) begin
               n = (frame_len != 0) ? int'(frame_len) : 1;
               if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
               for (int k = 0; k < n; k++) begin
                  beat.msgid = frame_id;
                  beat.sys = sys_byte;
                  beat.comp = comp_byte;
                  beat.seq = seq_byte;
                  beat.incompat = is_v2 ? incompat_flags : 8'h00;
                  beat.compat = is_v2 ? compat_flags : 8'h00;
                  beat.v2 = is_v2;
                  beat.length = frame_len;
                  beat.index = 6'(k);
                  beat.data = (frame_len != 0) ? payload_mem[k] : 8'h00;
                  beat.last = (k == n - 1);
                  beats_due.push_back(beat);
               end
               frames_passed++;
            end
         end
         default: link_phase = PH_IDLE;
      endcase
   endtask

   always @(posedge clock) begin
      frame_beat_type want;
      if (reset) begin
         clear_parser();
         beats_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (beats_due.size() == 0) begin
               log_error($sformatf("result with nothing expected, tdata %h", rsp_tdata));
            end else begin
               want = beats_due.pop_front();
               compare_field("message_id", rsp_tdata[23:0], want.msgid);
               compare_field("source_system", rsp_tdata[31:24], want.sys);
               compare_field("source_component", rsp_tdata[39:32], want.comp);
               compare_field("sequence_number", rsp_tdata[47:40], want.seq);
               compare_field("incompat_flags", rsp_tdata[55:48], want.incompat);
               compare_field("compat_flags", rsp_tdata[63:56], want.compat);
               compare_field("is_version_two", rsp_tdata[64], want.v2);
               compare_field("payload_length", rsp_tdata[71:65], want.length);
               compare_field("byte_index", rsp_tdata[77:72], want.index);
               compare_field("payload_byte", rsp_tdata[85:78], want.data);
               compare_field("last", rsp_tlast, want.last);
            end
         end
         if (req_tvalid && req_tready) parse_link_byte(req_tdata);
      end
      pending = beats_due.size();
   end

endmodule

FILE: bench/mavlink_frame_parser_tb.sv
// Top of the mavlink_frame_parser bench: clock, reset, link byte stimulus and result stalls.
// Instantiates the parser (mfp_pkg) and mavlink_frame_checker, which predicts and compares.
module mavlink_frame_parser_tb
   import mfp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int TARGET_BYTES = 480;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;    // message_id, source_system, source_component, sequence_number,
                              // incompat_flags, compat_flags, is_version_two, payload_length,
                              // byte_index, payload_byte, zero pad
   logic        rsp_tlast;

   int error_count;
   int pending;
   int results_checked;
   int frames_passed;

   int  bytes_sent;
   int  frames_built;
   int  input_stalls;
   int  burst_left;
   bit  hold_req;

   mavlink_frame_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   mavlink_frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) chk (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .error_count(error_count),
      .pending(pending),
      .results_checked(results_checked),
      .frames_passed(frames_passed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("mavlink_frame_parser_tb: done, errors");
      $finish;
   end

   function automatic logic [15:0] link_crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0]  t;
      logic [15:0] w;
      t = b ^ crc[7:0];
      t = t ^ (t << 4);
      w = {8'h00, t};
      return (crc >> 8) ^ (w << 8) ^ (w << 3) ^ (w >> 4);
   endfunction

   function automatic logic [23:0] pick_known_id();
      logic [23:0] ids [6];
      ids = '{MSG_HEARTBEAT, MSG_SYS_STATUS, MSG_ATTITUDE, MSG_GLOBAL_POS_INT,
              MSG_COMMAND_LONG, MSG_COMMAND_ACK};
      return ids[$urandom_range(0, 5)];
   endfunction

   function automatic logic [7:0] seal_byte(input logic [23:0] id);
      case (id)
         MSG_HEARTBEAT:      return 8'd50;
         MSG_SYS_STATUS:     return 8'd124;
         MSG_ATTITUDE:       return 8'd39;
         MSG_GLOBAL_POS_INT: return 8'd104;
         MSG_COMMAND_LONG:   return 8'd152;
         MSG_COMMAND_ACK:    return 8'd143;
         default:            return 8'd0;
      endcase
   endfunction

   // present one byte and hold it until taken; gaps fall between bursts
   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata = b;
      @(posedge clock);
      while (!req_tready) begin
         input_stalls++;
         @(posedge clock);
      end
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic put_frame(input bit v2, input int len, input logic [23:0] id, input bit spoil);
      logic [7:0]  body[$];
      logic [15:0] crc;
      logic [23:0] eff_id;
      eff_id = v2 ? id : {16'h0000, id[7:0]};
      body.push_back(8'(len));
      if (v2) begin
         body.push_back(8'($urandom));
         body.push_back(8'($urandom));
      end
      repeat (3) body.push_back(8'($urandom));
      body.push_back(eff_id[7:0]);
      if (v2) begin
         body.push_back(eff_id[15:8]);
         body.push_back(eff_id[23:16]);
      end
      repeat (len) body.push_back(8'($urandom));
      crc = CRC_SEED;
      foreach (body[i]) crc = link_crc_step(crc, body[i]);
      crc = link_crc_step(crc, seal_byte(eff_id));
      if (spoil) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      send_byte(v2 ? START_V2 : START_V1);
      foreach (body[i]) send_byte(body[i]);
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      frames_built++;
   endtask

   task automatic random_frame();
      int len;
      int pick;
      bit v2;
      logic [23:0] id;
      pick = $urandom_range(0, 15);
      len = (pick == 0) ? 0 : (pick == 1) ? MAX_PAYLOAD : $urandom_range(1, 16);
      v2 = 1'($urandom_range(0, 1));
      id = $urandom_range(0, 1) ? pick_known_id() : 24'($urandom);
      put_frame(v2, len, id, $urandom_range(0, 7) == 0);
   endtask

   task automatic random_traffic(input int until_bytes);
      int pick;
      while (bytes_sent < until_bytes) begin
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            random_frame();
         end else if (pick < 17) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else if (pick < 19) begin
            send_byte($urandom_range(0, 1) ? START_V2 : START_V1);
            send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
         end else begin
            // cut a frame short inside its header
            send_byte($urandom_range(0, 1) ? START_V2 : START_V1);
            send_byte(8'($urandom_range(0, 20)));
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   initial begin : receiver
      int mode;
      int span;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            for (int i = 0; i < span && !hold_req; i++) begin
               case (mode)
                  0:       rsp_tready = 1'b1;
                  1:       rsp_tready = 1'($urandom_range(0, 1));
                  2:       rsp_tready = ($urandom_range(0, 3) == 0);
                  default: rsp_tready = ($urandom_range(0, 7) != 0);
               endcase
               @(negedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      hold_req = 1'b0;
      bytes_sent = 0;
      frames_built = 0;
      input_stalls = 0;
      burst_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      put_frame(1'b0, 0, MSG_HEARTBEAT, 1'b0);
      send_byte(START_V1);
      send_byte(8'(MAX_PAYLOAD + 1));
      put_frame(1'b0, 0, MSG_COMMAND_ACK, 1'b1);
      put_frame(1'b1, 1, 24'hFFFFFF, 1'b0);
      wait_drained();

      put_frame(1'b1, MAX_PAYLOAD, pick_known_id(), 1'b0);
      random_traffic(200);

      // stall the result side while complete frames keep arriving
      hold_req = 1'b1;
      repeat (4) put_frame(1'($urandom_range(0, 1)), $urandom_range(24, 40),
                           pick_known_id(), 1'b0);

      random_traffic(TARGET_BYTES);

      wait_drained();
      $display("covered %0d link bytes in %0d built frames; %0d frames passed CRC",
               bytes_sent, frames_built, frames_passed);
      $display("checked %0d results; input stalled %0d cycles", results_checked, input_stalls);
      if (error_count == 0) begin
         $display("mavlink_frame_parser_tb: done, clean");
      end else begin
         $display("mavlink_frame_parser_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
design/mfp_pkg.sv
design/mfp_front.sv
design/mfp_queue.sv
design/mfp_back.sv
design/mavlink_frame_parser.sv
bench/mavlink_frame_checker.sv
bench/mavlink_frame_parser_tb.sv
